// ===== sv/cba_pkg.sv =====
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types for the contiguous block allocator: block tags, operation
// codes and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cba_pkg;

  typedef enum logic [2:0] {
    TAG_FREE   = 3'd0,
    TAG_SINGLE = 3'd1,
    TAG_FIRST  = 3'd2,
    TAG_CONT   = 3'd3,
    TAG_LAST   = 3'd4
  } tag_e;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic scan;
    logic mark;
    logic clear;
    logic emit;
    logic emit_ok;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic bad_req;
    logic hit;
    logic scan_end;
    logic wr_done;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/cba_ctrl.sv =====
// ----------------------------------------------------------------------------
// cba_ctrl
// Sequencer for the allocator: request check, tag scan, run marking,
// run clearing and hand-off of the response beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cba_ctrl import cba_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    req_valid_i,
  output logic         req_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_MARK,
    ST_CLEAR,
    ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   ok_q, ok_d;

  always_comb begin
    state_d      = state_q;
    ok_d         = ok_q;
    cmd_o        = '0;
    cmd_o.emit_ok = ok_q;
    req_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.prep = 1'b1;
        if (status_i.bad_req) begin
          ok_d    = 1'b0;
          state_d = ST_RESP;
        end else if (status_i.is_free) begin
          state_d = ST_CLEAR;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.hit) begin
          state_d = ST_MARK;
        end else if (status_i.scan_end) begin
          ok_d    = 1'b0;
          state_d = ST_RESP;
        end
      end
      ST_MARK: begin
        cmd_o.mark = 1'b1;
        if (status_i.wr_done) begin
          ok_d    = 1'b1;
          state_d = ST_RESP;
        end
      end
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.wr_done) begin
          ok_d    = 1'b1;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ok_q    <= ok_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cba_dp.sv =====
// ----------------------------------------------------------------------------
// cba_dp
// Datapath of the allocator: request registers, tag memory with per-block
// valid bits, scan pointer and run counter, and the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cba_dp import cba_pkg::*; #(
  parameter int BLOCKS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_t       cmd_i,
  output status_t         status_o,
  input  wire logic       req_func_i,
  input  wire logic [4:0] req_count_i,
  input  wire logic [3:0] req_start_i,
  output logic            rsp_valid_o,
  input  wire logic       rsp_ready_i,
  output logic            rsp_ok_o,
  output logic [3:0]      rsp_run_start_o
);

  localparam int IW = $clog2(BLOCKS);
  localparam int CW = $clog2(BLOCKS + 1);
  localparam int SW = ((CW > 5) ? CW : 5) + 1;
  localparam logic [SW-1:0] BLOCKS_W = SW'(BLOCKS);
  localparam logic [SW-1:0] LAST_W   = SW'(BLOCKS - 1);
  localparam logic [SW-1:0] ONE_W    = SW'(1);

  tag_e            mem_q [BLOCKS];
  logic [BLOCKS-1:0] valid_q;

  func_e           func_q;
  logic [SW-1:0]   want_q;
  logic [SW-1:0]   start_q;
  logic [SW-1:0]   end_q;
  logic [SW-1:0]   ptr_q;
  logic [SW-1:0]   run_q;
  logic [SW-1:0]   rd_idx_q;
  logic            rd_pend_q;
  logic            rd_valid_q;
  tag_e            rd_tag_q;

  logic            out_valid_q;
  logic            out_ok_q;
  logic [3:0]      out_start_q;

  logic [IW-1:0]   addr;
  logic            issue;
  logic            tag_is_free;
  logic            hit;
  logic [SW-1:0]   free_len;
  logic [SW-1:0]   free_sum;
  logic [SW-1:0]   free_end;
  tag_e            mark_tag;

  assign addr        = ptr_q[IW-1:0];
  assign issue       = (ptr_q < BLOCKS_W);
  assign tag_is_free = !rd_valid_q || (rd_tag_q == TAG_FREE);
  assign hit         = rd_pend_q && tag_is_free && ((run_q + ONE_W) == want_q);

  assign free_len = (want_q == '0) ? ONE_W : want_q;
  assign free_sum = start_q + free_len;
  assign free_end = (free_sum > BLOCKS_W) ? LAST_W : (free_sum - ONE_W);

  always_comb begin
    priority if (want_q == ONE_W) begin
      mark_tag = TAG_SINGLE;
    end else if (ptr_q == start_q) begin
      mark_tag = TAG_FIRST;
    end else if (ptr_q == end_q) begin
      mark_tag = TAG_LAST;
    end else begin
      mark_tag = TAG_CONT;
    end
  end

  always_comb begin
    status_o.is_free  = (func_q == FUNC_FREE);
    status_o.bad_req  = (func_q == FUNC_FREE) ? (start_q >= BLOCKS_W)
                                              : ((want_q == '0) || (want_q > BLOCKS_W));
    status_o.hit      = hit;
    status_o.scan_end = rd_pend_q && !hit && (rd_idx_q == LAST_W);
    status_o.wr_done  = (ptr_q == end_q);
    status_o.out_busy = out_valid_q && !rsp_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_e'(req_func_i);
      want_q  <= SW'(req_count_i);
      start_q <= SW'(req_start_i);
    end
    if (cmd_i.prep) begin
      if (func_q == FUNC_FREE) begin
        ptr_q <= start_q;
        end_q <= free_end;
      end else begin
        ptr_q <= '0;
      end
      run_q <= '0;
    end
    if (cmd_i.scan) begin
      rd_tag_q <= mem_q[addr];
      rd_idx_q <= ptr_q;
      if (rd_pend_q) begin
        run_q <= tag_is_free ? (run_q + ONE_W) : '0;
      end
      if (hit) begin
        start_q <= rd_idx_q + ONE_W - want_q;
        ptr_q   <= rd_idx_q + ONE_W - want_q;
        end_q   <= rd_idx_q;
      end else if (issue) begin
        ptr_q <= ptr_q + ONE_W;
      end
    end
    if (cmd_i.mark) begin
      mem_q[addr] <= mark_tag;
      ptr_q       <= ptr_q + ONE_W;
    end
    if (cmd_i.clear) begin
      mem_q[addr] <= TAG_FREE;
      ptr_q       <= ptr_q + ONE_W;
    end
    if (cmd_i.emit) begin
      out_ok_q    <= cmd_i.emit_ok;
      out_start_q <= (cmd_i.emit_ok && (func_q == FUNC_ALLOC)) ? start_q[3:0] : 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rd_pend_q   <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.prep) begin
        rd_pend_q <= 1'b0;
      end
      if (cmd_i.scan) begin
        rd_pend_q  <= issue && !hit;
        rd_valid_q <= valid_q[addr];
      end
      if (cmd_i.mark) begin
        valid_q[addr] <= 1'b1;
      end
      if (cmd_i.clear) begin
        valid_q[addr] <= 1'b0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o     = out_valid_q;
  assign rsp_ok_o        = out_ok_q;
  assign rsp_run_start_o = out_start_q;

endmodule

`default_nettype wire

// ===== sv/contiguous_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// contiguous_block_allocator_core
// First-fit allocator of contiguous block runs over a pool of BLOCKS tags.
// ----------------------------------------------------------------------------
//
//   Port group   Dir  Beat contents
//   s_axis       in   tuser: func; tdata: count, start_block
//   m_axis       out  tuser: ok;   tdata: run_start
//
// An allocate runs the load and check steps, scans one block per cycle up to
// the end of the first fitting run, then marks one block per cycle over the
// run, then loads the response once m_axis is free.
// A free runs the load and check steps, clears one block per cycle, then loads the response.
// The tag memory has a single port, so scan and marking share it in turn.
// Reset marks every block free at once through per-block valid bits.
// A new request is taken while the previous response still waits on m_axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module contiguous_block_allocator_core import cba_pkg::*; #(
  parameter int BLOCKS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // count[4:0], start_block[8:5], zero fill
  input  wire logic [0:0]  s_axis_tuser,  // func[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // run_start[3:0], zero fill
  output logic [0:0]       m_axis_tuser   // ok[0]
);

  cmd_t       cmd;
  status_t    status;
  logic       rsp_ok;
  logic [3:0] rsp_run_start;

  cba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cba_dp #(
    .BLOCKS (BLOCKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .req_func_i      (s_axis_tuser[0]),
    .req_count_i     (s_axis_tdata[4:0]),
    .req_start_i     (s_axis_tdata[8:5]),
    .rsp_valid_o     (m_axis_tvalid),
    .rsp_ready_i     (m_axis_tready),
    .rsp_ok_o        (rsp_ok),
    .rsp_run_start_o (rsp_run_start)
  );

  assign m_axis_tdata = {4'd0, rsp_run_start};
  assign m_axis_tuser = rsp_ok;

endmodule

`default_nettype wire

// ===== tb/tb_contiguous_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// tb_contiguous_block_allocator_core
// Self-checking bench for the first-fit contiguous block allocator. A local
// model of the tag pool predicts the response to every accepted request beat,
// and each response beat is compared with the oldest prediction. Directed
// requests cover the edges of the pool, then random traffic of allocations
// and frees runs under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_contiguous_block_allocator_core;
  import cba_pkg::*;

  localparam int BLOCKS = 16;

  typedef struct packed {
    logic       ok;
    logic [3:0] run_start;
  } alloc_resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // count[4:0], start_block[8:5], zero fill
  logic [0:0]  s_axis_tuser = '0;   // func[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // run_start[3:0], zero fill
  logic [0:0]  m_axis_tuser;        // ok[0]

  tag_e        pool_tags [BLOCKS];
  alloc_resp_t expected_resps [$];
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  contiguous_block_allocator_core #(
    .BLOCKS(BLOCKS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic alloc_resp_t predict_resp(func_e f, logic [4:0] cnt, logic [3:0] sb);
    alloc_resp_t r;
    int          run;
    int          stop;
    int          len;
    bit          found;
    r = '0;
    run = 0;
    found = 1'b0;
    if (f == FUNC_ALLOC) begin
      if (cnt != 0 && int'(cnt) <= BLOCKS) begin
        for (int i = 0; i < BLOCKS; i++) begin
          if (!found) begin
            if (pool_tags[i] == TAG_FREE) begin
              run++;
              if (run == int'(cnt)) begin
                found = 1'b1;
                r.ok = 1'b1;
                r.run_start = 4'(i + 1 - run);
                for (int j = i + 1 - run; j <= i; j++) pool_tags[j] = TAG_CONT;
                if (run == 1) begin
                  pool_tags[i] = TAG_SINGLE;
                end else begin
                  pool_tags[i + 1 - run] = TAG_FIRST;
                  pool_tags[i] = TAG_LAST;
                end
              end
            end else begin
              run = 0;
            end
          end
        end
      end
    end else if (int'(sb) < BLOCKS) begin
      len = (cnt == 0) ? 1 : int'(cnt);
      stop = int'(sb) + len;
      if (stop > BLOCKS) stop = BLOCKS;
      for (int i = int'(sb); i < stop; i++) pool_tags[i] = TAG_FREE;
      r.ok = 1'b1;
    end
    return r;
  endfunction

  task automatic send_req(func_e f, logic [4:0] cnt, logic [3:0] sb);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {7'd0, sb, cnt};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_resps.push_back(predict_resp(f, cnt, sb));
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 200) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_resps.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_mismatch(string what, alloc_resp_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: expected ok=%0b run_start=%0d, got ok=%0b run_start=%0d",
               what, want.ok, want.run_start, m_axis_tuser[0], m_axis_tdata[3:0]);
    end
  endtask

  always @(posedge clk_i) begin : resp_check
    alloc_resp_t want;
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_resps.size() == 0) begin
        note_mismatch("unexpected response beat", '0);
      end else begin
        want = expected_resps.pop_front();
        if (m_axis_tuser[0] !== want.ok || m_axis_tdata[3:0] !== want.run_start) begin
          note_mismatch("response mismatch", want);
        end
      end
    end
  end

  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_req(FUNC_ALLOC, 5'd0, 4'd15);
    send_req(FUNC_ALLOC, 5'd16, 4'd0);
    send_req(FUNC_ALLOC, 5'd1, 4'd0);
    send_req(FUNC_FREE, 5'd16, 4'd0);
    send_req(FUNC_ALLOC, 5'd1, 4'd15);
    send_req(FUNC_ALLOC, 5'd31, 4'd0);
    send_req(FUNC_ALLOC, 5'd17, 4'd0);
    send_req(FUNC_ALLOC, 5'd15, 4'd0);
    send_req(FUNC_FREE, 5'd31, 4'd15);
    send_req(FUNC_FREE, 5'd0, 4'd5);
    send_req(FUNC_ALLOC, 5'd1, 4'd0);
    send_req(FUNC_FREE, 5'd1, 4'd0);
    send_req(FUNC_ALLOC, 5'd2, 4'd0);
    send_req(FUNC_FREE, 5'd4, 4'd8);
    send_req(FUNC_ALLOC, 5'd4, 4'd0);
    send_req(FUNC_FREE, 5'd3, 4'd14);
    send_req(FUNC_ALLOC, 5'd2, 4'd0);
    send_req(FUNC_FREE, 5'd16, 4'd0);
    send_req(FUNC_ALLOC, 5'd3, 4'd10);
    send_req(FUNC_ALLOC, 5'd13, 4'd0);
    send_req(FUNC_ALLOC, 5'd1, 4'd0);
    send_req(FUNC_FREE, 5'd1, 4'd15);
    send_req(FUNC_ALLOC, 5'd1, 4'd0);
    send_req(FUNC_FREE, 5'd2, 4'd15);
    wait_for_drain();
  endtask

  task automatic test_random_traffic(int n_items, int send_pct, int recv_pct, bit pause_mid);
    int       pick;
    int       head;
    int       idx;
    int       len;
    func_e    f;
    logic [4:0] cnt;
    logic [3:0] sb;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int k = 0; k < n_items; k++) begin
      if (pause_mid && k == n_items / 2) wait_for_drain();
      pick = $urandom_range(99);
      sb = 4'($urandom_range(BLOCKS - 1));
      if (pick < 45) begin
        f = FUNC_ALLOC;
        cnt = 5'($urandom_range(8, 1));
      end else if (pick < 55) begin
        f = FUNC_ALLOC;
        cnt = 5'($urandom_range(31));
      end else if (pick < 88) begin
        f = FUNC_FREE;
        head = -1;
        for (int j = 0; j < BLOCKS; j++) begin
          idx = (int'(sb) + j) % BLOCKS;
          if (head < 0 && (pool_tags[idx] == TAG_SINGLE || pool_tags[idx] == TAG_FIRST)) begin
            head = idx;
          end
        end
        if (head >= 0) begin
          len = 1;
          if (pool_tags[head] == TAG_FIRST) begin
            while (head + len < BLOCKS && pool_tags[head + len] == TAG_CONT) len++;
            if (head + len < BLOCKS) len++;
          end
          sb = 4'(head);
          cnt = 5'(len);
        end else begin
          cnt = 5'($urandom_range(4, 1));
        end
      end else begin
        f = FUNC_FREE;
        cnt = 5'($urandom_range(31));
      end
      send_req(f, cnt, sb);
    end
    wait_for_drain();
  endtask

  initial begin
    for (int i = 0; i < BLOCKS; i++) pool_tags[i] = TAG_FREE;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_traffic(190, 0, 0, 1'b0);
    test_random_traffic(180, 88, 0, 1'b1);
    test_random_traffic(180, 0, 88, 1'b0);
    test_random_traffic(190, 7, 7, 1'b0);
    repeat (2 * BLOCKS + 8) @(posedge clk_i);
    if (expected_resps.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(50_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
